// ===== rtl/pal_pkg.sv =====
// Shared types and constants for the positional array list.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none
package pal_pkg;

  // Fixed field widths of the item and result ports
  localparam int OPC_W  = 2;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int STS_W  = 2;
  localparam int LEN_W  = 7;

  // Number of cells examined per step of a locate or delete scan
  localparam int SCAN_GROUP = 8;

  // Operation codes
  localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPC_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OPC_W-1:0] OP_LOCATE = 2'd2;

  // Status codes
  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_BAD_POS = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL    = 2'd2;

  // Cell command modes
  localparam int CM_W = 3;
  localparam logic [CM_W-1:0] CM_HOLD   = 3'd0;
  localparam logic [CM_W-1:0] CM_INSERT = 3'd1;
  localparam logic [CM_W-1:0] CM_DELETE = 3'd2;
  localparam logic [CM_W-1:0] CM_LOCATE = 3'd3;
  localparam logic [CM_W-1:0] CM_SCAN   = 3'd4;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic [CM_W-1:0]  mode;
    logic [POS_W-1:0] pos;
  } pal_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/pal_cell.sv =====
// One list cell: holds one element plus a scan flag and scan tap.
// Depends on pal_pkg for the command struct and mode codes.
`default_nettype none
module pal_cell #(
  parameter int ELEM_WIDTH = 32,
  parameter int CNT_W      = 7,
  parameter int IDX        = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pal_pkg::pal_cmd_t     cmd,
  input  wire logic [CNT_W-1:0]      count,
  input  wire logic [ELEM_WIDTH-1:0] value,
  input  wire logic [ELEM_WIDTH-1:0] left_elem,
  input  wire logic [ELEM_WIDTH-1:0] right_elem,
  input  wire logic [ELEM_WIDTH-1:0] up_tap,
  input  wire logic                  up_flag,
  output logic      [ELEM_WIDTH-1:0] elem,
  output logic      [ELEM_WIDTH-1:0] tap,
  output logic                       flag
);
  import pal_pkg::*;

  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [CMP_W-1:0] IDX1 = CMP_W'(IDX + 1);

  logic [ELEM_WIDTH-1:0] elem_r, elem_nxt;
  logic [ELEM_WIDTH-1:0] tap_r, tap_nxt;
  logic                  flag_r, flag_nxt;
  logic [CMP_W-1:0]      pos_x;
  logic [CMP_W-1:0]      cnt_x;

  assign pos_x = CMP_W'(cmd.pos);
  assign cnt_x = CMP_W'(count);

  // per-cell shift / compare decision
  always_comb begin
    elem_nxt = elem_r;
    tap_nxt  = tap_r;
    flag_nxt = flag_r;
    unique case (cmd.mode)
      CM_INSERT: begin
        if (IDX1 == pos_x) begin
          elem_nxt = value;
        end else if (IDX1 > pos_x) begin
          elem_nxt = left_elem;
        end
      end
      CM_DELETE: begin
        // capture the old value before the later elements move down
        tap_nxt  = elem_r;
        flag_nxt = (IDX1 == pos_x);
        if (IDX1 >= pos_x) begin
          elem_nxt = right_elem;
        end
      end
      CM_LOCATE: begin
        tap_nxt  = elem_r;
        flag_nxt = (elem_r == value) && (IDX1 <= cnt_x);
      end
      CM_SCAN: begin
        tap_nxt  = up_tap;
        flag_nxt = up_flag;
      end
      default: begin
      end
    endcase
  end

  // payload
  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
    tap_r  <= tap_nxt;
  end

  // scan flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else begin
      flag_r <= flag_nxt;
    end
  end

  assign elem = elem_r;
  assign tap  = tap_r;
  assign flag = flag_r;

endmodule
`default_nettype wire

// ===== rtl/pal_pick.sv =====
// Priority pick over the lowest scan lanes of the cell chain.
// Depends on pal_pkg only by convention; no shared types used.
`default_nettype none
module pal_pick #(
  parameter int LANES      = 8,
  parameter int ELEM_WIDTH = 32,
  parameter int OFF_W      = 3
) (
  input  wire logic [LANES-1:0]      flags,
  input  wire logic [ELEM_WIDTH-1:0] taps [LANES],
  output logic                       any,
  output logic      [OFF_W-1:0]      offset,
  output logic      [ELEM_WIDTH-1:0] value
);
  import pal_pkg::*;

  // lowest flagged lane wins
  always_comb begin
    offset = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (flags[i]) begin
        offset = OFF_W'(i);
      end
    end
  end

  // flag-masked OR of the taps (one flag set on delete)
  always_comb begin
    value = '0;
    for (int i = 0; i < LANES; i++) begin
      value = value | (taps[i] & {ELEM_WIDTH{flags[i]}});
    end
  end

  assign any = |flags;

endmodule
`default_nettype wire

// ===== rtl/positional_array_list_unit.sv =====
// Positional array list: an ordered list of up to CAPACITY values held in a
// chain of cells, one element per cell. Insert places a value at a 1-based
// position and moves the later elements up one cell; delete returns the
// element at a position and moves the later ones down; locate returns the
// first position holding a value, or 0. Each result carries a status and the
// list length. One item is worked at a time. Insert, unused opcodes and any
// rejected position load their result directly. Delete and locate shift and
// compare in every cell at once, then walk the scan flags down the chain
// eight cells per cycle until a hit or, for locate, the end of the list. The
// result waits in an output register; a stalled result holds off the next
// item. Depends on pal_pkg, pal_cell and pal_pick.
`default_nettype none
module positional_array_list_unit #(
  parameter int CAPACITY   = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [pal_pkg::OPC_W-1:0]    in_opcode,
  input  wire logic [pal_pkg::POS_W-1:0]    in_position,
  input  wire logic [pal_pkg::DATA_W-1:0]   in_item_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [pal_pkg::STS_W-1:0]    out_status,
  output logic      [pal_pkg::DATA_W-1:0]   out_removed_value,
  output logic      [pal_pkg::POS_W-1:0]    out_found_position,
  output logic      [pal_pkg::LEN_W-1:0]    out_list_length
);
  import pal_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int LANES = (CAPACITY < SCAN_GROUP) ? CAPACITY : SCAN_GROUP;
  localparam int OFF_W = $clog2(LANES);
  localparam int SUM_W = CNT_W + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                  state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      base_r, base_nxt;
  logic                  del_r, del_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STS_W-1:0]      out_status_r, out_status_nxt;
  logic [DATA_W-1:0]     out_removed_r, out_removed_nxt;
  logic [POS_W-1:0]      out_found_r, out_found_nxt;
  logic [LEN_W-1:0]      out_len_r, out_len_nxt;

  pal_cmd_t              cmd;
  logic [ELEM_WIDTH-1:0] value_e;
  logic                  out_free;
  logic                  in_fire;
  logic [CMP_W-1:0]      pos_x;
  logic [CMP_W-1:0]      cnt_x;
  logic                  ins_pos_ok;
  logic                  del_pos_ok;
  logic [SUM_W-1:0]      base_end;
  logic [SUM_W-1:0]      found_w;

  logic [ELEM_WIDTH-1:0] elem_a [CAPACITY];
  logic [ELEM_WIDTH-1:0] tap_a  [CAPACITY];
  logic [CAPACITY-1:0]   flag_v;
  logic [ELEM_WIDTH-1:0] pick_taps [LANES];
  logic                  pick_any;
  logic [OFF_W-1:0]      pick_off;
  logic [ELEM_WIDTH-1:0] pick_val;

  assign value_e  = ELEM_WIDTH'(in_item_value);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) && out_free);
  assign in_fire  = in_valid && !in_stall;

  assign pos_x      = CMP_W'(in_position);
  assign cnt_x      = CMP_W'(count_r);
  assign ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));
  assign del_pos_ok = (pos_x != '0) && (pos_x <= cnt_x);
  assign base_end   = SUM_W'(base_r) + SUM_W'(LANES);
  assign found_w    = SUM_W'(base_r) + SUM_W'(pick_off) + SUM_W'(1);

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] left_w;
    logic [ELEM_WIDTH-1:0] right_w;
    logic [ELEM_WIDTH-1:0] up_tap_w;
    logic                  up_flag_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = elem_a[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = elem_a[i+1];
    end

    if (i + LANES < CAPACITY) begin : g_up
      assign up_tap_w  = tap_a[i+LANES];
      assign up_flag_w = flag_v[i+LANES];
    end else begin : g_top
      assign up_tap_w  = '0;
      assign up_flag_w = 1'b0;
    end

    pal_cell #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .count      (count_r),
      .value      (value_e),
      .left_elem  (left_w),
      .right_elem (right_w),
      .up_tap     (up_tap_w),
      .up_flag    (up_flag_w),
      .elem       (elem_a[i]),
      .tap        (tap_a[i]),
      .flag       (flag_v[i])
    );
  end

  // bottom lanes feed the priority pick
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    assign pick_taps[k] = tap_a[k];
  end

  pal_pick #(
    .LANES      (LANES),
    .ELEM_WIDTH (ELEM_WIDTH),
    .OFF_W      (OFF_W)
  ) u_pick (
    .flags  (flag_v[LANES-1:0]),
    .taps   (pick_taps),
    .any    (pick_any),
    .offset (pick_off),
    .value  (pick_val)
  );

  // control: dispatch, scan, result load
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    base_nxt        = base_r;
    del_nxt         = del_r;
    cmd.mode        = CM_HOLD;
    cmd.pos         = in_position;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_found_nxt   = out_found_r;
    out_len_nxt     = out_len_r;

    if (state_r == ST_IDLE) begin
      if (in_fire) begin
        unique case (in_opcode)
          OP_INSERT: begin
            out_valid_nxt   = 1'b1;
            out_removed_nxt = '0;
            out_found_nxt   = '0;
            out_len_nxt     = LEN_W'(count_r);
            if (!ins_pos_ok) begin
              out_status_nxt = STS_BAD_POS;
            end else if (cnt_x >= CMP_W'(CAPACITY)) begin
              out_status_nxt = STS_FULL;
            end else begin
              out_status_nxt = STS_OK;
              cmd.mode       = CM_INSERT;
              count_nxt      = count_r + CNT_W'(1);
              out_len_nxt    = LEN_W'(count_r + CNT_W'(1));
            end
          end
          OP_DELETE: begin
            if (del_pos_ok) begin
              cmd.mode  = CM_DELETE;
              count_nxt = count_r - CNT_W'(1);
              base_nxt  = '0;
              del_nxt   = 1'b1;
              state_nxt = ST_SCAN;
            end else begin
              out_valid_nxt   = 1'b1;
              out_status_nxt  = STS_BAD_POS;
              out_removed_nxt = '0;
              out_found_nxt   = '0;
              out_len_nxt     = LEN_W'(count_r);
            end
          end
          OP_LOCATE: begin
            cmd.mode  = CM_LOCATE;
            base_nxt  = '0;
            del_nxt   = 1'b0;
            state_nxt = ST_SCAN;
          end
          default: begin
            out_valid_nxt   = 1'b1;
            out_status_nxt  = STS_OK;
            out_removed_nxt = '0;
            out_found_nxt   = '0;
            out_len_nxt     = LEN_W'(count_r);
          end
        endcase
      end
    end else begin
      // scan step: finish on a hit or past the list end, else move down
      if (pick_any || (!del_r && (base_end >= SUM_W'(count_r)))) begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = STS_OK;
          out_removed_nxt = del_r ? DATA_W'(pick_val) : '0;
          out_found_nxt   = (!del_r && pick_any) ? POS_W'(found_w) : '0;
          out_len_nxt     = LEN_W'(count_r);
          state_nxt       = ST_IDLE;
        end
      end else begin
        cmd.mode = CM_SCAN;
        base_nxt = CNT_W'(base_end);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // scan bookkeeping and result payload
  always_ff @(posedge clk) begin
    base_r        <= base_nxt;
    del_r         <= del_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_found_r   <= out_found_nxt;
    out_len_r     <= out_len_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_removed_value  = out_removed_r;
  assign out_found_position = out_found_r;
  assign out_list_length    = out_len_r;

`ifndef NO_ASSERTIONS
  // element count never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(CAPACITY))
    else $error("list count above capacity");

  // no transfer is taken while a scan is running
  a_scan_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> in_stall)
    else $error("input taken during scan");

  // a delete marks exactly the one cell it removes, at most
  a_del_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && del_r) |-> $onehot0(flag_v))
    else $error("delete scan with several flags");

  // an accepted valid delete shortens the list by one
  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_opcode == OP_DELETE && del_pos_ok)
      |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("delete did not shorten list");

  // a scan ends only by loading a result
  a_scan_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && state_nxt == ST_IDLE) |=> out_valid_r)
    else $error("scan finished without a result");
`endif

endmodule
`default_nettype wire

// ===== bench/pal_list_check_pkg.sv =====
// Result predictor and scoreboard for the positional array list bench.
// Depends on pal_pkg for field widths, operation codes and status codes.
`default_nettype none
package pal_list_check_pkg;
  import pal_pkg::*;

  localparam int LIST_CAP = 64;

  // One expected or observed result transfer
  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic [DATA_W-1:0] removed;
    logic [POS_W-1:0]  found;
    logic [LEN_W-1:0]  length;
  } list_result_t;

  class list_scoreboard;
    // Shadow copy of the list contents and length
    logic [DATA_W-1:0] cells [LIST_CAP];
    int                fill;
    list_result_t      pending [$];
    int                errors;
    int                checked;
    int                n_ops;
    int                n_full;
    int                n_bad_pos;
    int                n_hits;
    int                n_removed;

    function new();
      fill      = 0;
      errors    = 0;
      checked   = 0;
      n_ops     = 0;
      n_full    = 0;
      n_bad_pos = 0;
      n_hits    = 0;
      n_removed = 0;
    endfunction

    // Apply one accepted operation to the shadow list and queue its result
    function void note_op(logic [OPC_W-1:0] op, logic [POS_W-1:0] pos,
                          logic [DATA_W-1:0] val);
      list_result_t r;
      int p;
      r = '0;
      p = int'(pos);
      n_ops++;
      case (op)
        OP_INSERT: begin
          // position is checked before capacity
          if (p < 1 || p > fill + 1) begin
            r.status = STS_BAD_POS;
          end else if (fill >= LIST_CAP) begin
            r.status = STS_FULL;
          end else begin
            for (int j = fill; j >= p; j--) cells[j] = cells[j-1];
            cells[p-1] = val;
            fill++;
          end
        end
        OP_DELETE: begin
          if (p < 1 || p > fill) begin
            r.status = STS_BAD_POS;
          end else begin
            r.removed = cells[p-1];
            for (int j = p; j < fill; j++) cells[j-1] = cells[j];
            fill--;
            n_removed++;
          end
        end
        OP_LOCATE: begin
          for (int j = 0; j < fill; j++) begin
            if (cells[j] == val) begin
              r.found = POS_W'(j + 1);
              break;
            end
          end
          if (r.found != '0) n_hits++;
        end
        default: ;  // unused opcode: no change, status ok
      endcase
      if (r.status == STS_FULL) n_full++;
      if (r.status == STS_BAD_POS) n_bad_pos++;
      r.length = LEN_W'(fill);
      pending.push_back(r);
    endfunction

    // One line per mismatch, and a running count
    task report(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("mismatch: %s at result %0d, expected %0h, got %0h",
               what, checked, want, got);
    endtask

    // Compare one result transfer with the oldest expectation
    task check_result(list_result_t got);
      list_result_t want;
      if (pending.size() == 0) begin
        report("result with nothing outstanding", 64'd0, 64'(got));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.status !== want.status)
        report("status", 64'(want.status), 64'(got.status));
      if (got.removed !== want.removed)
        report("removed_value", 64'(want.removed), 64'(got.removed));
      if (got.found !== want.found)
        report("found_position", 64'(want.found), 64'(got.found));
      if (got.length !== want.length)
        report("list_length", 64'(want.length), 64'(got.length));
    endtask
  endclass

endpackage
`default_nettype wire

// ===== bench/tb_top.sv =====
// Top-level bench for positional_array_list_unit: directed and random list
// operations with random idling on both channels. Depends on pal_pkg and
// pal_list_check_pkg.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pal_pkg::*;
  import pal_list_check_pkg::*;

  localparam int OPS_PER_PHASE = 670;
  localparam int TARGET_SPAN   = 80;

  // Opcode with no operation behind it
  localparam logic [OPC_W-1:0] OP_SPARE = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OPC_W-1:0]  in_opcode = '0;
  logic [POS_W-1:0]  in_position = '0;
  logic [DATA_W-1:0] in_item_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STS_W-1:0]  out_status;
  logic [DATA_W-1:0] out_removed_value;
  logic [POS_W-1:0]  out_found_position;
  logic [LEN_W-1:0]  out_list_length;

  int             in_idle_pct = 13;
  int             out_idle_pct = 68;
  int             target_fill = LIST_CAP;
  list_scoreboard sb;

  positional_array_list_unit #(
    .CAPACITY   (LIST_CAP),
    .ELEM_WIDTH (DATA_W)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_position        (in_position),
    .in_item_value      (in_item_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_removed_value  (out_removed_value),
    .out_found_position (out_found_position),
    .out_list_length    (out_list_length)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #(5_000_000);
    $display("tb_top: done, errors");
    $finish;
  end

  // Receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_status, out_removed_value, out_found_position, out_list_length});
  end

  // Drive one operation; returns on the falling edge after its transfer
  task automatic send_op(input logic [OPC_W-1:0] op, input logic [POS_W-1:0] pos,
                         input logic [DATA_W-1:0] val);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_position   <= pos;
    in_item_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_op(op, pos, val);
    @(negedge clk);
  endtask

  // Value mix: a small pool for duplicates, the extremes, and full-range values
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(3, 0))
      0:       return DATA_W'($urandom_range(15, 0));
      1:       return $urandom_range(1, 0) ? '1 : '0;
      default: return $urandom();
    endcase
  endfunction

  // Mostly legal operations steered toward a target length, some noise
  function automatic void next_op(output logic [OPC_W-1:0] op,
                                  output logic [POS_W-1:0] pos,
                                  output logic [DATA_W-1:0] val);
    int roll;
    int len;
    bit grow;
    roll = $urandom_range(99, 0);
    len  = sb.fill;
    val  = pick_value();
    pos  = POS_W'($urandom_range(127, 0));
    if (roll < 15) begin
      op = OPC_W'($urandom_range(3, 0));
    end else if (roll < 35) begin
      op = OP_LOCATE;
      if (len > 0 && $urandom_range(99, 0) < 60)
        val = sb.cells[$urandom_range(len - 1, 0)];
    end else begin
      if (len < target_fill)      grow = ($urandom_range(99, 0) < 80);
      else if (len > target_fill) grow = ($urandom_range(99, 0) < 20);
      else                        grow = $urandom_range(1, 0);
      if (grow) begin
        op = OP_INSERT;
        case ($urandom_range(3, 0))
          0:       pos = POS_W'(1);
          1:       pos = POS_W'(len + 1);
          default: pos = POS_W'($urandom_range(len + 1, 1));
        endcase
      end else begin
        op  = OP_DELETE;
        pos = (len == 0) ? POS_W'(1) : POS_W'($urandom_range(len, 1));
      end
    end
  endfunction

  // Stimulus
  initial begin
    logic [OPC_W-1:0]  op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty list, bad positions, ends and middle, duplicates, unused opcode
    send_op(OP_LOCATE, 7'd0,   32'h0);
    send_op(OP_DELETE, 7'd1,   32'h0);
    send_op(OP_INSERT, 7'd0,   32'h1);
    send_op(OP_INSERT, 7'd2,   32'h1);
    send_op(OP_INSERT, 7'd1,   32'h0);
    send_op(OP_INSERT, 7'd2,   32'hFFFF_FFFF);
    send_op(OP_INSERT, 7'd1,   32'h5A5A_5A5A);
    send_op(OP_INSERT, 7'd2,   32'hFFFF_FFFF);
    send_op(OP_LOCATE, 7'd127, 32'hFFFF_FFFF);
    send_op(OP_LOCATE, 7'd0,   32'h0);
    send_op(OP_LOCATE, 7'd3,   32'h1234_5678);
    send_op(OP_SPARE,  7'd127, 32'hFFFF_FFFF);
    send_op(OP_DELETE, 7'd127, 32'hFFFF_FFFF);
    send_op(OP_DELETE, 7'd5,   32'h0);
    send_op(OP_INSERT, 7'd127, 32'hA5A5_A5A5);
    send_op(OP_DELETE, 7'd4,   32'h0);
    send_op(OP_DELETE, 7'd1,   32'h0);
    send_op(OP_INSERT, 7'd3,   32'hA5A5_A5A5);
    send_op(OP_DELETE, 7'd2,   32'h0);

    // Random: three idling phases, target length redrawn every span
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin in_idle_pct = 13; out_idle_pct = 68; end
        1:       begin in_idle_pct = 68; out_idle_pct = 13; end
        default: begin in_idle_pct = 0;  out_idle_pct = 0;  end
      endcase
      for (int n = 0; n < OPS_PER_PHASE; n++) begin
        if (n % TARGET_SPAN == 0 && !(phase == 0 && n == 0)) begin
          case ($urandom_range(3, 0))
            0:       target_fill = 0;
            1:       target_fill = LIST_CAP;
            default: target_fill = $urandom_range(LIST_CAP - 1, 1);
          endcase
        end
        next_op(op, pos, val);
        send_op(op, pos, val);
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then allow for a stray late transfer
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("tb_top: %0d operations sent, %0d results checked, %0d mismatches",
             sb.n_ops, sb.checked, sb.errors);
    $display("tb_top: %0d full rejects, %0d bad positions, %0d deletes, %0d locate hits",
             sb.n_full, sb.n_bad_pos, sb.n_removed, sb.n_hits);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== positional_array_list_unit.f =====
rtl/pal_pkg.sv
rtl/pal_cell.sv
rtl/pal_pick.sv
rtl/positional_array_list_unit.sv
bench/pal_list_check_pkg.sv
bench/tb_top.sv
